// File: src/pdc_pkg.sv
// Shared types and constants of the Pareto dominance compare unit.
`timescale 1ns / 1ps
`default_nettype none

package pdc_pkg;

  // Fixed field widths of one word on each channel.
  localparam int FIT_W      = 32;
  localparam int BIN_W      = 16;
  localparam int MAX_DIMS   = 4;
  localparam int MASK_W     = MAX_DIMS;
  localparam int FIT_TOL_W  = 31;
  localparam int SCORE_W    = 5;

  // Stream widths: fields packed from bit 0 up, padded to whole bytes.
  localparam int IN_TDATA_W  = 2 * FIT_W + 2 * MAX_DIMS * BIN_W;
  localparam int OUT_TDATA_W = 8;

  // Configuration channel.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MAXIMISE_MASK = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FITNESS_TOL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_TOL_0     = 3'd2;

  // Defaults for the top-level parameters.
  localparam int DEF_DIMS     = 4;
  localparam int DEF_BIN_BITS = 16;

  // Reset values of the registers.
  localparam logic [MASK_W-1:0]    MASK_RST    = 4'hF;
  localparam logic [FIT_TOL_W-1:0] FIT_TOL_RST = '0;
  localparam logic [BIN_W-1:0]     BIN_TOL_RST = 16'd1;

  typedef struct packed {
    logic [MAX_DIMS-1:0][BIN_W-1:0] bin_tol;
    logic [FIT_TOL_W-1:0]           fit_tol;
    logic [MASK_W-1:0]              max_mask;
  } cfg_t;

  typedef struct packed {
    logic [MAX_DIMS-1:0][BIN_W-1:0] rhs_bin;
    logic [MAX_DIMS-1:0][BIN_W-1:0] lhs_bin;
    logic signed [FIT_W-1:0]        rhs_fitness;
    logic signed [FIT_W-1:0]        lhs_fitness;
  } item_t;

endpackage

`default_nettype wire

// File: src/pdc_core.sv
// Combinational dominance score for one candidate pair.
`timescale 1ns / 1ps
`default_nettype none

module pdc_core #(
  parameter int DIMS     = pdc_pkg::DEF_DIMS,
  parameter int BIN_BITS = pdc_pkg::DEF_BIN_BITS
) (
  input  pdc_pkg::cfg_t                       cfg,
  input  pdc_pkg::item_t                      item,
  output logic signed [pdc_pkg::SCORE_W-1:0]  score
);

  localparam int BIN_W    = pdc_pkg::BIN_W;
  localparam int FIT_W    = pdc_pkg::FIT_W;
  localparam int SCORE_W  = pdc_pkg::SCORE_W;
  localparam int BIN_USED = (BIN_BITS < BIN_W) ? BIN_BITS : BIN_W;
  localparam int CNT_W    = $clog2(DIMS + 2);
  localparam logic [BIN_W:0]   ONE_EXT  = 1;
  localparam logic [BIN_W-1:0] BIN_MASK = BIN_W'((ONE_EXT << BIN_USED) - ONE_EXT);

  // Fitness: always maximized. Bit DIMS of the vectors below is the fitness.
  logic signed [FIT_W:0] fit_diff;
  logic [FIT_W:0]        fit_abs;
  logic                  fit_ne;
  logic                  fit_over;

  logic [DIMS:0] pos_v;
  logic [DIMS:0] neg_v;
  logic [DIMS:0] over_v;
  logic [DIMS-1:0] tol_zero_v;

  assign fit_diff = {item.lhs_fitness[FIT_W-1], item.lhs_fitness}
                  - {item.rhs_fitness[FIT_W-1], item.rhs_fitness};
  assign fit_ne   = (item.lhs_fitness != item.rhs_fitness);
  assign fit_abs  = fit_diff[FIT_W] ? (FIT_W + 1)'(-fit_diff) : fit_diff;
  assign fit_over = fit_abs > {2'b00, cfg.fit_tol};

  assign pos_v[DIMS]  = fit_ne && !fit_diff[FIT_W];
  assign neg_v[DIMS]  = fit_ne && fit_diff[FIT_W];
  assign over_v[DIMS] = fit_over;

  for (genvar i = 0; i < DIMS; i++) begin : g_dim
    logic [BIN_W-1:0] lb;
    logic [BIN_W-1:0] rb;
    logic [BIN_W-1:0] tol;
    logic [BIN_W-1:0] absd;
    logic             ne;
    logic             gt;
    logic             better;

    assign lb     = item.lhs_bin[i] & BIN_MASK;
    assign rb     = item.rhs_bin[i] & BIN_MASK;
    assign tol    = cfg.bin_tol[i] & BIN_MASK;
    assign ne     = (lb != rb);
    assign gt     = (lb > rb);
    assign better = (gt == cfg.max_mask[i]);
    assign absd   = gt ? (lb - rb) : (rb - lb);

    assign pos_v[i]      = ne && better;
    assign neg_v[i]      = ne && !better;
    assign over_v[i]     = absd > tol;
    assign tol_zero_v[i] = (tol == '0);
  end

  logic [CNT_W-1:0]          cnt;
  logic                      any_pos;
  logic                      any_neg;
  logic                      tolerant;
  logic                      in_tol;
  logic signed [SCORE_W-1:0] sum;
  logic signed [SCORE_W-1:0] seen;

  always_comb begin
    cnt = '0;
    for (int k = 0; k <= DIMS; k++) begin
      cnt = cnt + CNT_W'(pos_v[k] | neg_v[k]);
    end
    any_pos  = |pos_v;
    any_neg  = |neg_v;
    tolerant = (cfg.fit_tol != '0) && !(|tol_zero_v);
    in_tol   = !(|over_v);
    sum      = any_neg ? -$signed(SCORE_W'(cnt)) : $signed(SCORE_W'(cnt));
    seen     = any_neg ? -SCORE_W'(1) : (any_pos ? SCORE_W'(1) : '0);

    if (any_pos && any_neg) begin
      score = '0;
    end else if (tolerant && in_tol) begin
      score = seen;
    end else if (tolerant) begin
      score = sum <<< 1;
    end else begin
      score = sum;
    end
  end

endmodule

`default_nettype wire

// File: src/pareto_dominance_compare_unit.sv
// Top level of the Pareto dominance compare unit: stream ports, registers, pipeline.
`timescale 1ns / 1ps
`default_nettype none

// A result word passes the input register, then the result register, to out_tdata.
// One word per cycle while out_tready holds; the input register and the result
// register each hand on their word as soon as the next stage can take it.
// Reset (rst_n low, synchronous) empties both stages and restores the registers:
// maximise_mask to all ones, fitness_tolerance to 0, every bin tolerance to 1.
// The configuration channel is always ready and takes one write per cycle.
module pareto_dominance_compare_unit #(
  parameter int DIMS     = pdc_pkg::DEF_DIMS,
  parameter int BIN_BITS = pdc_pkg::DEF_BIN_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Input stream. in_tdata, lowest bit up: lhs_fitness[31:0], rhs_fitness[31:0],
  // lhs_bin_0..3 (16 bits each), rhs_bin_0..3 (16 bits each).
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [pdc_pkg::IN_TDATA_W-1:0]    in_tdata,
  // Result stream. out_tdata, lowest bit up: dominance_score[4:0], three zero bits.
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [pdc_pkg::OUT_TDATA_W-1:0]        out_tdata,
  // Register write channel.
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [pdc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [pdc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int FIT_W     = pdc_pkg::FIT_W;
  localparam int BIN_W     = pdc_pkg::BIN_W;
  localparam int MAX_DIMS  = pdc_pkg::MAX_DIMS;
  localparam int SCORE_W   = pdc_pkg::SCORE_W;
  localparam int CFG_IDX_W = pdc_pkg::CFG_IDX_W;
  localparam int SCORE_MAX = 2 * (DIMS + 1);
  localparam int SCORE_MIN = -SCORE_MAX;

  // ---------------------------------------------------------------------
  // Configuration registers. The user must only issue writes while the unit is idle;
  // the block itself does not enforce it, and the score logic reads them directly.
  // ---------------------------------------------------------------------
  pdc_pkg::cfg_t cfg_r;
  logic          cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // One tolerance register per bin dimension; indexes past the last are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_mask <= pdc_pkg::MASK_RST;
      cfg_r.fit_tol  <= pdc_pkg::FIT_TOL_RST;
      for (int i = 0; i < MAX_DIMS; i++) begin
        cfg_r.bin_tol[i] <= pdc_pkg::BIN_TOL_RST;
      end
    end else if (cfg_we) begin
      if (cfg_index == pdc_pkg::REG_MAXIMISE_MASK) begin
        cfg_r.max_mask <= cfg_data[pdc_pkg::MASK_W-1:0];
      end
      if (cfg_index == pdc_pkg::REG_FITNESS_TOL) begin
        cfg_r.fit_tol <= cfg_data[pdc_pkg::FIT_TOL_W-1:0];
      end
      for (int i = 0; i < MAX_DIMS; i++) begin
        if (cfg_index == CFG_IDX_W'(pdc_pkg::REG_BIN_TOL_0 + i)) begin
          cfg_r.bin_tol[i] <= cfg_data[BIN_W-1:0];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Unpack the input word.
  // ---------------------------------------------------------------------
  pdc_pkg::item_t in_item;

  always_comb begin
    in_item.lhs_fitness = $signed(in_tdata[FIT_W-1:0]);
    in_item.rhs_fitness = $signed(in_tdata[2*FIT_W-1:FIT_W]);
    for (int i = 0; i < MAX_DIMS; i++) begin
      in_item.lhs_bin[i] = in_tdata[2*FIT_W + i*BIN_W +: BIN_W];
      in_item.rhs_bin[i] = in_tdata[2*FIT_W + (MAX_DIMS + i)*BIN_W +: BIN_W];
    end
  end

  // ---------------------------------------------------------------------
  // Two-stage pipeline: input register, score logic, result register.
  // Each stage loads whenever it is empty or its word leaves in the same cycle,
  // so a word enters every cycle while the result side keeps taking.
  // ---------------------------------------------------------------------
  pdc_pkg::item_t            item_r;
  logic                      item_vld_r;
  logic signed [SCORE_W-1:0] score;
  logic signed [SCORE_W-1:0] out_score_r;
  logic                      out_vld_r;
  logic                      out_load;
  logic                      in_load;

  assign out_load  = !out_vld_r || out_tready;
  assign in_tready = !item_vld_r || out_load;
  assign in_load   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_tready) begin
      item_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      item_r <= in_item;
    end
  end

  pdc_core #(
    .DIMS     (DIMS),
    .BIN_BITS (BIN_BITS)
  ) u_core (
    .cfg   (cfg_r),
    .item  (item_r),
    .score (score)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= item_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && item_vld_r) begin
      out_score_r <= score;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {(pdc_pkg::OUT_TDATA_W - SCORE_W)'(0), out_score_r};

`ifndef SYNTHESIS
  // A word in the input register that cannot move on stays there.
  assert property (@(posedge clk) disable iff (!rst_n)
    (item_vld_r && !out_load) |=> item_vld_r)
    else $error("input register dropped a stalled word");

  // An accepted input word always lands in the input register.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_load |=> item_vld_r)
    else $error("accepted word not captured");

  // A valid result never exceeds twice the number of compared components.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_score_r >= SCORE_MIN && out_score_r <= SCORE_MAX))
    else $error("dominance score out of range");

  // Reset empties the result stage.
  assert property (@(posedge clk)
    !rst_n |=> !out_vld_r)
    else $error("result valid after reset");
`endif

endmodule

`default_nettype wire

// File: test/pareto_dominance_compare_unit_tb.sv
// Self-checking testbench of the Pareto dominance compare unit: directed and random pairs.
`timescale 1ns / 1ps

module pareto_dominance_compare_unit_tb;

  localparam int FIT_W       = pdc_pkg::FIT_W;
  localparam int BIN_W       = pdc_pkg::BIN_W;
  localparam int MAX_DIMS    = pdc_pkg::MAX_DIMS;
  localparam int MASK_W      = pdc_pkg::MASK_W;
  localparam int FIT_TOL_W   = pdc_pkg::FIT_TOL_W;
  localparam int SCORE_W     = pdc_pkg::SCORE_W;
  localparam int IN_TDATA_W  = pdc_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = pdc_pkg::OUT_TDATA_W;
  localparam int CFG_IDX_W   = pdc_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W  = pdc_pkg::CFG_DATA_W;

  localparam int LATENCY      = 2;
  localparam int STALL_CYCLES = 160;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_REPORTS  = 10;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_WORDS  = 110;
  localparam int STALL_WORDS  = 48;

  // Register indexes that decode to nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  localparam logic signed [FIT_W-1:0] FIT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [FIT_W-1:0] FIT_MIN = 32'sh8000_0000;

  typedef struct {
    pdc_pkg::item_t     pair;
    logic [SCORE_W-1:0] score;
  } score_exp_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  // Shadow copy of the register file, updated on every accepted write.
  logic [MASK_W-1:0]              sh_mask    = pdc_pkg::MASK_RST;
  logic [FIT_TOL_W-1:0]           sh_fit_tol = pdc_pkg::FIT_TOL_RST;
  logic [MAX_DIMS-1:0][BIN_W-1:0] sh_bin_tol = {MAX_DIMS{pdc_pkg::BIN_TOL_RST}};

  score_exp_t pending_scores[$];
  int         mismatch_count = 0;
  int         cycle_count    = 0;

  // Traffic shaping: random idling on both sides and one long receiver stall.
  bit idle_on       = 1'b1;
  bit stall_go      = 1'b0;
  bit stall_latched = 1'b0;
  int stall_left    = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  pareto_dominance_compare_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Expected score of one pair under the current shadow registers.
  function automatic logic [SCORE_W-1:0] predict_dominance(pdc_pkg::item_t pair);
    longint           lf;
    longint           rf;
    longint           fdiff;
    int               sum;
    int               seen;
    int               d;
    int               score;
    bit               in_tol;
    bit               tolerant;
    bit               maxi;
    logic [BIN_W-1:0] lb;
    logic [BIN_W-1:0] rb;
    logic [BIN_W-1:0] bdiff;
    lf       = longint'($signed(pair.lhs_fitness));
    rf       = longint'($signed(pair.rhs_fitness));
    sum      = 0;
    seen     = 0;
    in_tol   = 1'b1;
    tolerant = (sh_fit_tol != '0);
    if (lf != rf) begin
      seen  = (lf > rf) ? 1 : -1;
      sum   = seen;
      fdiff = (lf > rf) ? lf - rf : rf - lf;
      if (fdiff > longint'(sh_fit_tol)) in_tol = 1'b0;
    end
    for (int i = 0; i < MAX_DIMS; i++) begin
      lb   = pair.lhs_bin[i];
      rb   = pair.rhs_bin[i];
      maxi = sh_mask[i];
      if (sh_bin_tol[i] == '0) tolerant = 1'b0;
      if (lb == rb) continue;
      d     = ((lb > rb) == maxi) ? 1 : -1;
      bdiff = (lb > rb) ? lb - rb : rb - lb;
      if (bdiff > sh_bin_tol[i]) in_tol = 1'b0;
      // Components pulling in both directions make the pair incomparable.
      if (seen != 0 && d != seen) return '0;
      seen = d;
      sum += d;
    end
    score = tolerant ? (in_tol ? seen : 2 * sum) : sum;
    return score[SCORE_W-1:0];
  endfunction

  function automatic pdc_pkg::item_t pair_of(logic signed [FIT_W-1:0] lf,
                                             logic signed [FIT_W-1:0] rf,
                                             logic [MAX_DIMS-1:0][BIN_W-1:0] lb,
                                             logic [MAX_DIMS-1:0][BIN_W-1:0] rb);
    pdc_pkg::item_t pair;
    pair.lhs_fitness = lf;
    pair.rhs_fitness = rf;
    pair.lhs_bin     = lb;
    pair.rhs_bin     = rb;
    return pair;
  endfunction

  // Differences cluster around zero and around the tolerance edge.
  function automatic logic [31:0] pick_delta(logic [31:0] tol);
    case ($urandom_range(5))
      0, 1:    return '0;
      2:       return $urandom_range(1, 3);
      3:       return (tol == '0) ? 32'd1 : tol;
      4:       return tol + 32'd1;
      default: return $urandom();
    endcase
  endfunction

  // Mostly coherent pairs (one side better or equal everywhere), some mixed, some noise.
  function automatic pdc_pkg::item_t make_pair();
    pdc_pkg::item_t   pair;
    bit               lhs_wins;
    bit               better;
    logic [31:0]      fd;
    logic [BIN_W-1:0] bd;
    pair.lhs_fitness = $urandom();
    if ($urandom_range(99) < 10) begin
      pair.rhs_fitness = $urandom();
      for (int i = 0; i < MAX_DIMS; i++) begin
        pair.lhs_bin[i] = BIN_W'($urandom());
        pair.rhs_bin[i] = BIN_W'($urandom());
      end
      return pair;
    end
    lhs_wins = $urandom_range(1);
    fd = pick_delta(32'(sh_fit_tol));
    pair.rhs_fitness = lhs_wins ? pair.lhs_fitness - fd : pair.lhs_fitness + fd;
    for (int i = 0; i < MAX_DIMS; i++) begin
      better = lhs_wins;
      if ($urandom_range(99) < 12) better = !better;
      bd = BIN_W'(pick_delta(32'(sh_bin_tol[i])));
      pair.lhs_bin[i] = BIN_W'($urandom());
      // The first candidate is better when it is larger in a maximised dimension.
      pair.rhs_bin[i] = (better == sh_mask[i]) ? pair.lhs_bin[i] - bd : pair.lhs_bin[i] + bd;
    end
    return pair;
  endfunction

  task automatic send_pair(pdc_pkg::item_t pair);
    while (idle_on && $urandom_range(99) < 14) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pair;
    do @(posedge clk); while (!in_tready);
    pending_scores.insert(pending_scores.size(),
                          '{pair: pair, score: predict_dominance(pair)});
  endtask

  // Stop sending, let every result come out, then let the pipeline settle.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      pdc_pkg::REG_MAXIMISE_MASK: sh_mask    = data[MASK_W-1:0];
      pdc_pkg::REG_FITNESS_TOL:   sh_fit_tol = data[FIT_TOL_W-1:0];
      REG_SPARE_6, REG_SPARE_7:   ;
      default: sh_bin_tol[2'(idx - pdc_pkg::REG_BIN_TOL_0)] = data[BIN_W-1:0];
    endcase
  endtask

  // Writes all six registers; bits above each register width carry junk.
  task automatic set_config(logic [MASK_W-1:0] mask, logic [FIT_TOL_W-1:0] ftol,
                            logic [MAX_DIMS-1:0][BIN_W-1:0] btol);
    logic [CFG_DATA_W-1:0] junk;
    wait_idle();
    junk = $urandom();
    write_reg(pdc_pkg::REG_MAXIMISE_MASK, {junk[CFG_DATA_W-1:MASK_W], mask});
    write_reg(pdc_pkg::REG_FITNESS_TOL, {junk[CFG_DATA_W-1:FIT_TOL_W], ftol});
    for (int i = 0; i < MAX_DIMS; i++)
      write_reg(CFG_IDX_W'(pdc_pkg::REG_BIN_TOL_0 + i),
                {junk[CFG_DATA_W-1:BIN_W], btol[i]});
    cfg_valid <= 1'b0;
  endtask

  // Reset values: all dimensions maximised, fitness tolerance zero, so strict mode.
  task automatic test_reset_defaults();
    send_pair(pair_of(32'sd0, 32'sd0, '0, '0));
    send_pair(pair_of(FIT_MAX, FIT_MAX, {4{16'hFFFF}}, {4{16'hFFFF}}));
    send_pair(pair_of(FIT_MAX, FIT_MIN, {4{16'hFFFF}}, '0));
    send_pair(pair_of(FIT_MIN, FIT_MAX, '0, {4{16'hFFFF}}));
    send_pair(pair_of(32'sd5, -32'sd5, {16'd0, 16'd0, 16'd0, 16'd1},
                      {16'd0, 16'd0, 16'd0, 16'd2}));
    send_pair(pair_of(-32'sd1, 32'sd0, '0, '0));
    send_pair(pair_of(32'sd0, 32'sd0, {16'd9, 16'd0, 16'd0, 16'd0},
                      {16'd3, 16'd0, 16'd0, 16'd0}));
  endtask

  // Dimensions 0 and 2 maximised, 1 and 3 minimised, all tolerances non-zero.
  task automatic test_tolerant_mode();
    pdc_pkg::item_t near_win;
    near_win = pair_of(32'sd1050, 32'sd1000, {16'd7, 16'd5, 16'd10, 16'd12},
                       {16'd9, 16'd5, 16'd12, 16'd10});
    set_config(4'b0101, 31'd100, {4{16'd3}});
    send_pair(near_win);
    send_pair(pair_of(32'sd1200, 32'sd1000, near_win.lhs_bin, near_win.rhs_bin));
    send_pair(pair_of(near_win.rhs_fitness, near_win.lhs_fitness,
                      near_win.rhs_bin, near_win.lhs_bin));
    send_pair(pair_of(32'sd1000, 32'sd1000, near_win.lhs_bin, near_win.lhs_bin));
    send_pair(pair_of(32'sd1050, 32'sd1000, {16'd0, 16'd0, 16'd12, 16'd0},
                      {16'd0, 16'd0, 16'd10, 16'd0}));
    send_pair(pair_of(32'sd100, 32'sd0, {16'd0, 16'd0, 16'd0, 16'd3}, '0));
    // Writes to indexes beyond the register file must leave the setting alone.
    wait_idle();
    write_reg(REG_SPARE_6, '0);
    write_reg(REG_SPARE_7, '1);
    cfg_valid <= 1'b0;
    send_pair(near_win);
  endtask

  task automatic test_tolerance_extremes();
    set_config(4'hF, 31'h7FFF_FFFF, {4{16'hFFFF}});
    send_pair(pair_of(FIT_MAX, FIT_MIN, {4{16'hFFFF}}, '0));
    send_pair(pair_of(FIT_MAX, 32'sd0, {4{16'hFFFF}}, '0));
    send_pair(pair_of(FIT_MIN, -32'sd1, '0, {4{16'hFFFF}}));
    send_pair(pair_of(FIT_MIN, FIT_MAX, '0, {4{16'hFFFF}}));
  endtask

  // A single zero bin tolerance keeps the unit in strict mode.
  task automatic test_zero_bin_tolerance();
    set_config(4'h0, 31'd5, {16'd0, 16'd9, 16'd9, 16'd9});
    send_pair(pair_of(32'sd10, 32'sd8, '0, {4{16'd1}}));
    send_pair(pair_of(32'sd8, 32'sd10, {4{16'd1}}, '0));
  endtask

  task automatic test_random_settings();
    logic [MASK_W-1:0]              mask;
    logic [FIT_TOL_W-1:0]           ftol;
    logic [MAX_DIMS-1:0][BIN_W-1:0] btol;
    for (int p = 0; p < RAND_PHASES; p++) begin
      mask = MASK_W'($urandom());
      ftol = FIT_TOL_W'($urandom_range(1, 2000));
      for (int i = 0; i < MAX_DIMS; i++) btol[i] = BIN_W'($urandom_range(1, 8));
      case (p)
        0: begin
          ftol = '0;
          for (int i = 0; i < MAX_DIMS; i++) btol[i] = BIN_W'($urandom_range(0, 4));
        end
        1: ;
        2: begin
          mask = '0;
          ftol = '1;
          btol = {4{16'hFFFF}};
        end
        3: begin
          mask = '1;
          ftol = 31'd1;
          btol = {4{16'd1}};
        end
        4: btol[2'($urandom_range(MAX_DIMS - 1))] = '0;
        default: begin
          ftol = FIT_TOL_W'($urandom());
          btol = {$urandom(), $urandom()};
        end
      endcase
      set_config(mask, ftol, btol);
      // Two phases run without any idling on either side.
      idle_on <= (p != 3 && p != 4);
      for (int n = 0; n < PHASE_WORDS; n++) send_pair(make_pair());
    end
    idle_on <= 1'b1;
  endtask

  // The receiver holds off while the sender keeps offering, so the input stalls.
  task automatic test_backpressure();
    idle_on  <= 1'b0;
    stall_go <= 1'b1;
    for (int n = 0; n < STALL_WORDS; n++) send_pair(make_pair());
    stall_go <= 1'b0;
    idle_on  <= 1'b1;
  endtask

  // Result-side ready: random idling, plus the long stall when requested.
  always @(posedge clk) begin
    if (stall_go && !stall_latched) begin
      stall_latched <= 1'b1;
      stall_left    <= STALL_CYCLES;
      out_tready    <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !(idle_on && $urandom_range(99) < 14);
    end
    if (!stall_go) stall_latched <= 1'b0;
  end

  // Every result word is checked against the oldest expected score.
  always @(posedge clk) begin
    score_exp_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_scores.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result word %h with no pair outstanding", out_tdata);
      end else begin
        want = pending_scores.pop_front();
        if (out_tdata !== {{(OUT_TDATA_W - SCORE_W){1'b0}}, want.score}) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("score mismatch: fit %0d vs %0d, expected %0d got %0d (word %h)",
                     want.pair.lhs_fitness, want.pair.rhs_fitness, $signed(want.score),
                     $signed(out_tdata[SCORE_W-1:0]), out_tdata);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("pareto_dominance_compare_unit test failed");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_tolerant_mode();
    test_tolerance_extremes();
    test_zero_bin_tolerance();
    test_random_settings();
    test_backpressure();
    wait_idle();
    if (mismatch_count == 0 && pending_scores.size() == 0) begin
      $display("pareto_dominance_compare_unit test passed");
    end else begin
      $display("pareto_dominance_compare_unit test failed");
    end
    $finish;
  end

endmodule
